// ===== hw/rtl/bsde_pkg.sv =====
// Shared types and constants for the B-spline de Boor evaluator.
// No dependencies; every other file of the block imports it.
package bsde_pkg;

	localparam int XW = 32;
	localparam int SLOT_W = 7;
	localparam int SEG_W = 7;
	localparam int OP_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int ORDER_W = 4;
	localparam int POINTS_W = 7;
	localparam int TOL_W = 16;

	localparam logic [ORDER_W-1:0] ORDER_RST = 4'd4;
	localparam logic [POINTS_W-1:0] POINTS_RST = 7'd4;
	localparam logic [TOL_W-1:0] TOL_RST = 16'd0;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_KNOT = 2'd0,
		OP_LOAD_POINT = 2'd1,
		OP_EVAL = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORDER = 2'd0,
		CFG_POINTS = 2'd1,
		CFG_TOL = 2'd2
	} cfg_idx_t;

	// one step of the blend unit per strobe
	typedef struct packed {
		logic mul_a;
		logic mul_b;
		logic sum;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hw/rtl/bsde_if.sv =====
// Valid/ready channel interfaces: evaluator requests, results and config writes.
// Depends on bsde_pkg.
interface bsde_req_if import bsde_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] opcode;
	logic [SLOT_W-1:0] slot;
	logic signed [XW-1:0] knot_value;
	logic signed [XW-1:0] coord_x;
	logic signed [XW-1:0] coord_y;
	logic signed [XW-1:0] coord_z;
	logic signed [XW-1:0] eval_param;

	modport source (output valid, opcode, slot, knot_value, coord_x, coord_y, coord_z,
		eval_param, input ready);
	modport sink (input valid, opcode, slot, knot_value, coord_x, coord_y, coord_z,
		eval_param, output ready);
endinterface

interface bsde_rsp_if import bsde_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [XW-1:0] point_x;
	logic signed [XW-1:0] point_y;
	logic signed [XW-1:0] point_z;
	logic [SEG_W-1:0] segment;

	modport source (output valid, point_x, point_y, point_z, segment, input ready);
	modport sink (input valid, point_x, point_y, point_z, segment, output ready);
endinterface

interface bsde_cfg_if import bsde_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bsde_div.sv =====
// Restoring signed divider, one quotient bit per cycle, result saturated to 32 bits.
// Depends on bsde_pkg.
module bsde_div import bsde_pkg::*; #(
	parameter int NUM_W = 49
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [XW:0]      den,
	output div_stat_t               stat,
	output logic signed [XW-1:0]    quot
);

	localparam int CW = $clog2(NUM_W + 1);

	logic busy_q, fin_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [XW:0] dmag_q;
	logic [XW:0] rem_q;
	logic [XW+1:0] rem_sh;
	logic [XW+2:0] trial;
	logic signed [XW-1:0] quot_q;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign trial = {1'b0, rem_sh} - (XW+3)'(dmag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q && !fin_q) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q && !fin_q) begin
			neg_q <= num[NUM_W-1] ^ den[XW];
			quo_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			dmag_q <= den[XW] ? (XW+1)'(-den) : (XW+1)'(den);
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[XW+2]) begin
				rem_q <= trial[XW:0];
			end else begin
				rem_q <= rem_sh[XW:0];
			end
			quo_q <= {quo_q[NUM_W-2:0], ~trial[XW+2]};
		end else if (fin_q) begin
			// clamp the truncated quotient to the signed 32-bit range
			if (!neg_q) begin
				quot_q <= (quo_q > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
					: $signed(quo_q[XW-1:0]);
			end else begin
				quot_q <= (quo_q > NUM_W'(33'h0_8000_0000)) ? $signed(32'h8000_0000)
					: $signed(-quo_q[XW-1:0]);
			end
		end
	end

	assign stat.busy = busy_q | fin_q;
	assign stat.done = done_q;
	assign quot = quot_q;

endmodule

// ===== hw/rtl/bsde_mac.sv =====
// Blend unit: w*p1 and (1-w)*p0 as two products in separate steps, floor shift, add, saturate.
// Depends on bsde_pkg.
module bsde_mac import bsde_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  mac_ctl_t             ctl,
	input  logic signed [XW-1:0] w,
	input  logic signed [XW-1:0] p,
	output logic signed [XW-1:0] res
);

	localparam int OW = XW + 2;
	localparam int PAW = 2 * XW;
	localparam int PBW = OW + XW;
	localparam int SW = PBW + 1;
	localparam logic signed [SW-1:0] S_MAX = SW'(32'sh7FFF_FFFF);
	localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

	logic signed [OW-1:0] omw;
	logic signed [PAW-1:0] prod_a_q;
	logic signed [PBW-1:0] prod_b_q;
	logic signed [SW-1:0] sum;
	logic signed [XW-1:0] res_q;

	assign omw = (OW'(1) <<< FRAC_BITS) - OW'(w);
	assign sum = SW'(prod_a_q >>> FRAC_BITS) + SW'(prod_b_q >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (ctl.mul_a) begin
			prod_a_q <= w * p;
		end
		if (ctl.mul_b) begin
			prod_b_q <= omw * p;
		end
		if (ctl.sum) begin
			if (sum > S_MAX) begin
				res_q <= 32'sh7FFF_FFFF;
			end else if (sum < S_MIN) begin
				res_q <= $signed(32'h8000_0000);
			end else begin
				res_q <= sum[XW-1:0];
			end
		end
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/bspline_de_boor_evaluator.sv =====
// De Boor B-spline evaluator top: tables, segment search, blend sequencer.
// Accepted loads write in-range table slots. An evaluation runs search, fill and output
// plus k(k-1)/2 blend pairs, each with a division (skipped for a zero knot span), n points,
// order k; the divider is serial, one bit a cycle. Accepts no requests while evaluating
// (config writes are always taken); asynchronous active-low reset clears control and
// config, tables hold whatever was last written. Depends on bsde_pkg, bsde_if, div, mac.
module bspline_de_boor_evaluator import bsde_pkg::*; #(
	parameter int MAX_ORDER = 8,
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bsde_req_if.sink   req_ch,
	bsde_rsp_if.source rsp_ch,
	bsde_cfg_if.sink   cfg_ch
);

	localparam int KNOT_DEPTH = MAX_POINTS + MAX_ORDER;
	localparam int AW = $clog2(KNOT_DEPTH);
	localparam int IW = $clog2(KNOT_DEPTH + 1);
	localparam int CAW = $clog2(MAX_POINTS);
	localparam int KW = $clog2(MAX_ORDER + 1);
	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam int SAW = $clog2(MAX_ORDER);
	localparam int NUM_W = XW + 1 + FRAC_BITS;

	typedef enum logic [17:0] {
		ST_IDLE    = 18'h00001,
		ST_SR_A    = 18'h00002,
		ST_SR_B    = 18'h00004,
		ST_SR_C    = 18'h00008,
		ST_SCAN    = 18'h00010,
		ST_FILL_RD = 18'h00020,
		ST_FILL_WR = 18'h00040,
		ST_KA      = 18'h00080,
		ST_KB      = 18'h00100,
		ST_DIV     = 18'h00200,
		ST_DIVW    = 18'h00400,
		ST_RDP     = 18'h00800,
		ST_MA      = 18'h01000,
		ST_MB      = 18'h02000,
		ST_MC      = 18'h04000,
		ST_WB      = 18'h08000,
		ST_OUT_RD  = 18'h10000,
		ST_OUT     = 18'h20000
	} state_t;

	state_t state_q;

	logic [ORDER_W-1:0] curve_order_q;
	logic [POINTS_W-1:0] point_count_q;
	logic [TOL_W-1:0] tol_q;

	logic [KW-1:0] k_q, k_c, j_q, r_q, j_nx;
	logic [PW-1:0] n_q, n_c;
	logic [31:0] n_t;
	logic [IW-1:0] ind_q, i_q, fi, ind_fin, a_idx, b_idx, p_idx;
	logic [1:0] ax_q;
	logic signed [XW-1:0] t_q, ka_q, w_q;
	logic out_valid_q;
	logic signed [XW-1:0] px_q, py_q, pz_q;
	logic [SEG_W-1:0] seg_q;

	// tables
	logic signed [XW-1:0] knot_mem [KNOT_DEPTH];
	logic signed [XW-1:0] cx_mem [MAX_POINTS];
	logic signed [XW-1:0] cy_mem [MAX_POINTS];
	logic signed [XW-1:0] cz_mem [MAX_POINTS];
	logic signed [XW-1:0] sx_mem [MAX_ORDER];
	logic signed [XW-1:0] sy_mem [MAX_ORDER];
	logic signed [XW-1:0] sz_mem [MAX_ORDER];
	logic signed [XW-1:0] knot_rd_q, cx_rd_q, cy_rd_q, cz_rd_q;
	logic signed [XW-1:0] slo_x_q, slo_y_q, slo_z_q, shi_x_q, shi_y_q, shi_z_q;
	logic [AW-1:0] knot_ra;
	logic [CAW-1:0] ctrl_ra;
	logic [SAW-1:0] s_lo_a, s_hi_a;
	logic s_rd_en;

	logic req_acc, knot_wr, pt_wr;
	logic [AW-1:0] knot_wa;
	logic [CAW-1:0] pt_wa;

	logic signed [XW+1:0] d_tk, d_kt, tol_s;
	logic le_tk, le_kt;
	logic signed [XW:0] span;

	logic div_start;
	div_stat_t div_stat;
	logic signed [XW-1:0] div_quot;
	logic signed [NUM_W-1:0] div_num;

	mac_ctl_t mac_ctl;
	logic signed [XW-1:0] mac_p, mac_res;

	assign req_acc = req_ch.valid && req_ch.ready;
	assign req_ch.ready = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;

	assign knot_wa = AW'(req_ch.slot);
	assign pt_wa = CAW'(req_ch.slot);
	assign knot_wr = req_acc && (op_t'(req_ch.opcode) == OP_LOAD_KNOT)
		&& (32'(req_ch.slot) < KNOT_DEPTH);
	assign pt_wr = req_acc && (op_t'(req_ch.opcode) == OP_LOAD_POINT)
		&& (32'(req_ch.slot) < MAX_POINTS);

	// order and point count clamps
	always_comb begin
		if (curve_order_q < ORDER_W'(2)) begin
			k_c = KW'(2);
		end else if (32'(curve_order_q) > MAX_ORDER) begin
			k_c = KW'(MAX_ORDER);
		end else begin
			k_c = KW'(curve_order_q);
		end
		n_t = (32'(point_count_q) < 32'(k_c)) ? 32'(k_c) : 32'(point_count_q);
		n_c = (n_t > MAX_POINTS) ? PW'(MAX_POINTS) : PW'(n_t);
	end

	assign tol_s = $signed((XW+2)'(tol_q));
	assign d_tk = (XW+2)'(t_q) - (XW+2)'(knot_rd_q);
	assign d_kt = (XW+2)'(knot_rd_q) - (XW+2)'(t_q);
	assign le_tk = (d_tk <= tol_s);
	assign le_kt = (d_kt <= tol_s);

	// scan exit index
	assign fi = le_kt ? (i_q + 1'b1) : i_q;
	assign ind_fin = (fi < (IW'(k_q) + 1'b1)) ? (IW'(k_q) - 1'b1) : (fi - IW'(2));

	assign a_idx = ind_q + IW'(r_q) + IW'(j_q) + IW'(2) - IW'(k_q);
	assign b_idx = ind_q + IW'(j_q) + 1'b1;
	assign p_idx = ind_q + 1'b1 - IW'(k_q) + IW'(j_q);
	assign j_nx = j_q + 1'b1;
	assign ctrl_ra = p_idx[CAW-1:0];

	assign span = (XW+1)'(knot_rd_q) - (XW+1)'(ka_q);
	assign div_num = $signed({(XW+1)'(t_q) - (XW+1)'(ka_q), {FRAC_BITS{1'b0}}});
	assign div_start = (state_q == ST_DIV) && (span != '0);

	always_comb begin
		unique case (state_q)
			ST_SR_A: knot_ra = AW'(k_q - 1'b1);
			ST_SR_B: knot_ra = AW'(n_q);
			ST_SCAN: knot_ra = i_q[AW-1:0];
			ST_KA: knot_ra = a_idx[AW-1:0];
			ST_KB: knot_ra = b_idx[AW-1:0];
			default: knot_ra = '0;
		endcase
	end

	assign s_rd_en = (state_q == ST_RDP) || (state_q == ST_OUT_RD);
	assign s_lo_a = (state_q == ST_OUT_RD) ? '0 : j_q[SAW-1:0];
	assign s_hi_a = j_nx[SAW-1:0];

	always_ff @(posedge clk) begin
		if (knot_wr) begin
			knot_mem[knot_wa] <= req_ch.knot_value;
		end
		knot_rd_q <= knot_mem[knot_ra];
	end

	always_ff @(posedge clk) begin
		if (pt_wr) begin
			cx_mem[pt_wa] <= req_ch.coord_x;
			cy_mem[pt_wa] <= req_ch.coord_y;
			cz_mem[pt_wa] <= req_ch.coord_z;
		end
		cx_rd_q <= cx_mem[ctrl_ra];
		cy_rd_q <= cy_mem[ctrl_ra];
		cz_rd_q <= cz_mem[ctrl_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL_WR) begin
			sx_mem[j_q[SAW-1:0]] <= cx_rd_q;
			sy_mem[j_q[SAW-1:0]] <= cy_rd_q;
			sz_mem[j_q[SAW-1:0]] <= cz_rd_q;
		end else if (state_q == ST_WB) begin
			unique case (ax_q)
				2'd0: sx_mem[j_q[SAW-1:0]] <= mac_res;
				2'd1: sy_mem[j_q[SAW-1:0]] <= mac_res;
				default: sz_mem[j_q[SAW-1:0]] <= mac_res;
			endcase
		end
		if (s_rd_en) begin
			slo_x_q <= sx_mem[s_lo_a];
			slo_y_q <= sy_mem[s_lo_a];
			slo_z_q <= sz_mem[s_lo_a];
			shi_x_q <= sx_mem[s_hi_a];
			shi_y_q <= sy_mem[s_hi_a];
			shi_z_q <= sz_mem[s_hi_a];
		end
	end

	always_comb begin
		unique case ({state_q == ST_MA, ax_q})
			3'b100: mac_p = shi_x_q;
			3'b101: mac_p = shi_y_q;
			3'b110, 3'b111: mac_p = shi_z_q;
			3'b000: mac_p = slo_x_q;
			3'b001: mac_p = slo_y_q;
			default: mac_p = slo_z_q;
		endcase
	end

	assign mac_ctl.mul_a = (state_q == ST_MA);
	assign mac_ctl.mul_b = (state_q == ST_MB);
	assign mac_ctl.sum = (state_q == ST_MC);

	bsde_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (span),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	bsde_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.w   (w_q),
		.p   (mac_p),
		.res (mac_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_order_q <= ORDER_RST;
			point_count_q <= POINTS_RST;
			tol_q <= TOL_RST;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			unique case (cfg_idx_t'(cfg_ch.index))
				CFG_ORDER: curve_order_q <= cfg_ch.data[ORDER_W-1:0];
				CFG_POINTS: point_count_q <= cfg_ch.data[POINTS_W-1:0];
				CFG_TOL: tol_q <= cfg_ch.data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			k_q <= '0;
			n_q <= '0;
			ind_q <= '0;
			i_q <= '0;
			j_q <= '0;
			r_q <= '0;
			ax_q <= '0;
		end else begin
			if (rsp_ch.ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && (op_t'(req_ch.opcode) == OP_EVAL)) begin
						k_q <= k_c;
						n_q <= n_c;
						state_q <= ST_SR_A;
					end
				end
				ST_SR_A: state_q <= ST_SR_B;
				ST_SR_B: begin
					if (le_tk) begin
						ind_q <= IW'(k_q) - 1'b1;
						j_q <= '0;
						state_q <= ST_FILL_RD;
					end else begin
						state_q <= ST_SR_C;
					end
				end
				ST_SR_C: begin
					j_q <= '0;
					if (le_kt) begin
						ind_q <= IW'(n_q) - 1'b1;
						state_q <= ST_FILL_RD;
					end else begin
						i_q <= IW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance while the knot stays within tolerance and points remain
					if (le_kt && (i_q < IW'(n_q))) begin
						i_q <= i_q + 1'b1;
					end else begin
						ind_q <= ind_fin;
						state_q <= ST_FILL_RD;
					end
				end
				ST_FILL_RD: state_q <= ST_FILL_WR;
				ST_FILL_WR: begin
					if (j_nx == k_q) begin
						j_q <= '0;
						r_q <= '0;
						state_q <= ST_KA;
					end else begin
						j_q <= j_nx;
						state_q <= ST_FILL_RD;
					end
				end
				ST_KA: state_q <= ST_KB;
				ST_KB: state_q <= ST_DIV;
				ST_DIV: state_q <= (span == '0) ? ST_RDP : ST_DIVW;
				ST_DIVW: begin
					if (div_stat.done) begin
						state_q <= ST_RDP;
					end
				end
				ST_RDP: begin
					ax_q <= '0;
					state_q <= ST_MA;
				end
				ST_MA: state_q <= ST_MB;
				ST_MB: state_q <= ST_MC;
				ST_MC: state_q <= ST_WB;
				ST_WB: begin
					if (ax_q != 2'd2) begin
						ax_q <= ax_q + 1'b1;
						state_q <= ST_MA;
					end else if ((IW'(j_q) + IW'(r_q) + IW'(2)) < IW'(k_q)) begin
						j_q <= j_nx;
						state_q <= ST_KA;
					end else if ((IW'(r_q) + IW'(2)) < IW'(k_q)) begin
						r_q <= r_q + 1'b1;
						j_q <= '0;
						state_q <= ST_KA;
					end else begin
						state_q <= ST_OUT_RD;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the previous result has left
					if (!out_valid_q || rsp_ch.ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			t_q <= req_ch.eval_param;
		end
		if (state_q == ST_KB) begin
			ka_q <= knot_rd_q;
		end
		if (state_q == ST_DIV && span == '0) begin
			w_q <= '0;
		end else if (state_q == ST_DIVW && div_stat.done) begin
			w_q <= div_quot;
		end
		if (state_q == ST_OUT && (!out_valid_q || rsp_ch.ready)) begin
			px_q <= slo_x_q;
			py_q <= slo_y_q;
			pz_q <= slo_z_q;
			seg_q <= SEG_W'(ind_q);
		end
	end

	assign rsp_ch.valid = out_valid_q;
	assign rsp_ch.point_x = px_q;
	assign rsp_ch.point_y = py_q;
	assign rsp_ch.point_z = pz_q;
	assign rsp_ch.segment = seg_q;

`ifndef ASSERT_OFF
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_eval_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req_ch.opcode == OP_EVAL) |=> !req_ch.ready)
		else $error("request taken during evaluation");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");
`endif

endmodule

// ===== dv/bspline_de_boor_evaluator_tb.sv =====
// Testbench for the B-spline de Boor evaluator: loads knot and point tables, evaluates
// curve points and checks them against a predictor kept in a small scoreboard class.
// Depends on bsde_pkg, bsde_if and the evaluator RTL.
`timescale 1ns / 1ps

module bspline_de_boor_evaluator_tb;
	import bsde_pkg::*;

	localparam int MAXK = 8;
	localparam int MAXN = 64;
	localparam int FB = 16;
	localparam int KDEPTH = MAXN + MAXK;
	localparam longint LIMIT = 20_000_000;

	typedef struct {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [XW-1:0] z;
		logic [SEG_W-1:0] seg;
	} curve_pt_t;

	class curve_scoreboard;
		logic signed [XW-1:0] knots[KDEPTH];
		logic signed [XW-1:0] px[MAXN], py[MAXN], pz[MAXN];
		int unsigned order_reg, count_reg, tol_reg;
		curve_pt_t pending[$];
		int mismatches;

		function new();
			order_reg = ORDER_RST;
			count_reg = POINTS_RST;
			tol_reg = TOL_RST;
			mismatches = 0;
			foreach (knots[i]) knots[i] = 0;
			foreach (px[i]) begin
				px[i] = 0; py[i] = 0; pz[i] = 0;
			end
		endfunction

		function void write_reg(cfg_idx_t idx, int unsigned v);
			case (idx)
				CFG_ORDER: order_reg = v & 4'hf;
				CFG_POINTS: count_reg = v & 7'h7f;
				CFG_TOL: tol_reg = v & 16'hffff;
				default: ;
			endcase
		endfunction

		static function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		static function longint flr(longint v);
			return v >>> FB;
		endfunction

		function int unsigned locate(longint t, int unsigned k, int unsigned n);
			longint tol;
			int unsigned i;
			tol = tol_reg;
			if (t - longint'(knots[k-1]) <= tol) return k - 1;
			if (longint'(knots[n]) - t <= tol) return n - 1;
			i = 0;
			do i++; while (i - 1 < n && longint'(knots[i-1]) - t <= tol);
			if (i < k + 1) return k - 1;
			return i - 2;
		endfunction

		function void note_request(op_t op, int unsigned slot, logic signed [XW-1:0] kv,
				logic signed [XW-1:0] cx, logic signed [XW-1:0] cy, logic signed [XW-1:0] cz,
				logic signed [XW-1:0] tp);
			int unsigned k, n, seg;
			longint t, ka, kb, span, w, v;
			longint b[3][MAXK];
			curve_pt_t e;
			if (op == OP_LOAD_KNOT) begin
				if (slot < KDEPTH) knots[slot] = kv;
				return;
			end
			if (op == OP_LOAD_POINT) begin
				if (slot < MAXN) begin
					px[slot] = cx; py[slot] = cy; pz[slot] = cz;
				end
				return;
			end
			if (op != OP_EVAL) return;
			k = order_reg;
			if (k < 2) k = 2;
			if (k > MAXK) k = MAXK;
			n = count_reg;
			if (n < k) n = k;
			if (n > MAXN) n = MAXN;
			t = tp;
			seg = locate(t, k, n);
			for (int j = 0; j < k; j++) begin
				b[0][j] = px[seg+1-k+j];
				b[1][j] = py[seg+1-k+j];
				b[2][j] = pz[seg+1-k+j];
			end
			for (int r = 0; r + 1 < k; r++)
				for (int j = 0; j + r + 1 < k; j++) begin
					ka = knots[seg+r+j+2-k];
					kb = knots[seg+j+1];
					span = kb - ka;
					w = 0;
					if (span != 0) w = sat(((t - ka) * (64'sd1 << FB)) / span);
					for (int a = 0; a < 3; a++) begin
						v = flr(w * b[a][j+1]) + flr(((64'sd1 << FB) - w) * b[a][j]);
						b[a][j] = sat(v);
					end
				end
			e.x = XW'(b[0][0]); e.y = XW'(b[1][0]); e.z = XW'(b[2][0]);
			e.seg = SEG_W'(seg);
			pending.push_back(e);
		endfunction

		function void check_point(curve_pt_t got);
			curve_pt_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result x=%0d seg=%0d", got.x, got.seg);
				return;
			end
			e = pending.pop_front();
			if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.seg !== e.seg) begin
				mismatches++;
				if (mismatches <= 10)
					$display("point mismatch: exp %0d %0d %0d seg %0d, got %0d %0d %0d seg %0d",
						e.x, e.y, e.z, e.seg, got.x, got.y, got.z, got.seg);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	bsde_req_if req_ch();
	bsde_rsp_if rsp_ch();
	bsde_cfg_if cfg_ch();

	bspline_de_boor_evaluator uut (
		.clk(clk), .arst_n(arst_n), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	curve_scoreboard board = new();
	int send_idle_pct = 28;
	int recv_idle_pct = 72;
	bit recv_hold = 0;
	int unsigned cur_n = 4;
	longint cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: sample at the rising edge, stall at the falling edge
	always @(posedge clk) begin
		curve_pt_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.x = rsp_ch.point_x; got.y = rsp_ch.point_y;
			got.z = rsp_ch.point_z; got.seg = rsp_ch.segment;
			board.check_point(got);
		end
	end

	always @(negedge clk)
		rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

	task automatic send_request(op_t op, int unsigned slot, logic signed [XW-1:0] kv,
			logic signed [XW-1:0] cx, logic signed [XW-1:0] cy, logic signed [XW-1:0] cz,
			logic signed [XW-1:0] tp);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 0;
			@(negedge clk);
		end
		req_ch.valid = 1;
		req_ch.opcode <= op; req_ch.slot <= SLOT_W'(slot); req_ch.knot_value <= kv;
		req_ch.coord_x <= cx; req_ch.coord_y <= cy; req_ch.coord_z <= cz;
		req_ch.eval_param <= tp;
		do @(posedge clk); while (!req_ch.ready);
		board.note_request(op, slot, kv, cx, cy, cz, tp);
		@(negedge clk);
		req_ch.valid = 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (3000) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned v);
		cfg_ch.valid = 1; cfg_ch.index <= idx; cfg_ch.data <= CFG_DATA_W'(v);
		do @(posedge clk); while (!cfg_ch.ready);
		board.write_reg(idx, v);
		@(negedge clk);
		cfg_ch.valid = 0;
	endtask

	task automatic load_knot(int unsigned s, logic signed [XW-1:0] v);
		send_request(OP_LOAD_KNOT, s, v, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic load_point(int unsigned s, logic signed [XW-1:0] x, logic signed [XW-1:0] y,
			logic signed [XW-1:0] z);
		send_request(OP_LOAD_POINT, s, $urandom, x, y, z, $urandom);
	endtask

	task automatic evaluate(logic signed [XW-1:0] t);
		send_request(OP_EVAL, $urandom_range(127), $urandom, $urandom, $urandom, $urandom, t);
	endtask

	// fill every knot and point slot; knots rise by up to step, some random if wild
	task automatic load_curve(int unsigned step, bit wild);
		int signed kv;
		kv = -int'(step) * 4;
		for (int i = 0; i < KDEPTH; i++) begin
			if (wild && $urandom_range(3) == 0) load_knot(i, $urandom);
			else load_knot(i, kv);
			if ($urandom_range(3) != 0) kv += $urandom_range(step);
		end
		for (int i = 0; i < MAXN; i++)
			if (wild) load_point(i, $urandom, $urandom, $urandom);
			else load_point(i, $urandom_range(2000000) - 1000000,
				$urandom_range(2000000) - 1000000, $urandom_range(2000000) - 1000000);
	endtask

	task automatic configure(int unsigned k, int unsigned n, int unsigned tol);
		drain();
		write_reg(CFG_ORDER, k);
		write_reg(CFG_POINTS, n);
		write_reg(CFG_TOL, tol);
		cur_n = n;
	endtask

	function automatic logic signed [XW-1:0] pick_param();
		logic signed [XW-1:0] top;
		top = board.knots[(cur_n < 64 ? cur_n : 64) + 1];
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $urandom_range(top > 0 ? top : 1) - 100;
		endcase
	endfunction

	task automatic run_phase(int items);
		for (int i = 0; i < items; i++)
			case ($urandom_range(19))
				0: load_knot($urandom_range(127), $urandom);
				1: load_point($urandom_range(127), $urandom, $urandom, $urandom);
				2: send_request(op_t'(2'd3), $urandom_range(127), $urandom, $urandom, $urandom,
					$urandom, $urandom);
				default: evaluate(pick_param());
			endcase
	endtask

	initial begin
		req_ch.valid = 0; req_ch.opcode = OP_EVAL; req_ch.slot = 0; req_ch.knot_value = 0;
		req_ch.coord_x = 0; req_ch.coord_y = 0; req_ch.coord_z = 0; req_ch.eval_param = 0;
		cfg_ch.valid = 0; cfg_ch.index = CFG_ORDER; cfg_ch.data = 0;
		rsp_ch.ready = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: tables at extremes, clamping, ignored items
		load_curve(65536, 0);
		load_point(0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		load_point(1, 32'sh80000000, 32'sh7fffffff, 0);
		evaluate(32'sh80000000);
		evaluate(32'sh7fffffff);
		evaluate(0);
		evaluate(32'sh00020000);
		load_knot(100, $urandom);
		load_point(70, $urandom, $urandom, $urandom);
		send_request(op_t'(2'd3), 5, $urandom, $urandom, $urandom, $urandom, $urandom);
		configure(0, 0, 16'hffff);
		evaluate(32'sh00010000);
		evaluate(32'sh80000000);
		configure(15, 127, 0);
		evaluate(32'sh00100000);
		evaluate(32'sh7fffffff);
		configure(8, 64, 0);
		load_knot(20, 32'sh7fffffff);
		load_knot(21, 32'sh80000000);
		evaluate(32'sh00080000);
		load_knot(30, board.knots[29]);
		evaluate(board.knots[29]);
		configure(2, 2, 1);
		evaluate(32'sh00000010);

		// random phases over several settings
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 72 : 0;
			recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 28 : 0;
			for (int s = 0; s < 4; s++) begin
				configure($urandom_range(2, 8), $urandom_range(2, 20),
					$urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(4));
				if (s == 0 || s == 3)
					load_curve($urandom_range(1) ? 65536 : $urandom_range(2000000), s == 3);
				run_phase(30);
			end
			// long receiver stall while requests keep coming
			if (ph == 1) begin
				fork
					begin
						recv_hold = 1;
						repeat (5000) @(negedge clk);
						recv_hold = 0;
					end
					run_phase(10);
				join
			end
			// sender pause until everything has returned
			while (board.pending.size() != 0) @(negedge clk);
		end
		configure(8, 64, 65535);
		load_curve(65536, 0);
		run_phase(30);

		drain();
		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== bspline_de_boor_evaluator.f =====
hw/rtl/bsde_pkg.sv
hw/rtl/bsde_if.sv
hw/rtl/bsde_div.sv
hw/rtl/bsde_mac.sv
hw/rtl/bspline_de_boor_evaluator.sv
dv/bspline_de_boor_evaluator_tb.sv
